// ===== sv/assoc_key_value_table_macros.svh =====
// ----------------------------------------------------------------------------
// assoc_key_value_table assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSOC_KEY_VALUE_TABLE_MACROS_SVH
`define ASSOC_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication
`define AKVT_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("akvt assertion failed");

// next-cycle implication
`define AKVT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("akvt assertion failed");

`endif

// ===== sv/akvt_pkg.sv =====
// ----------------------------------------------------------------------------
// akvt_pkg
// Types, codes and helpers shared by the key/value table modules.
// ----------------------------------------------------------------------------
package akvt_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [IdxW-1:0]    idx_t;

  typedef enum logic [1:0] {
    KIND_SET     = 2'd0,
    KIND_GET     = 2'd1,
    KIND_CLR_KEY = 2'd2,
    KIND_CLR_VAL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_FOUND = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4
  } status_e;

  // classified operation, zero-handle requests already folded into OP_BAD
  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_GET     = 3'd1,
    OP_CLR_KEY = 3'd2,
    OP_CLR_VAL = 3'd3,
    OP_BAD     = 3'd4
  } op_e;

  typedef struct packed {
    kind_e   kind;
    handle_t key_handle;
    handle_t value_handle;
  } req_t;

  typedef struct packed {
    status_e    status;
    handle_t    result_value;
    handle_t    displaced_value;
    logic [3:0] slot_index;
  } rsp_t;

  typedef struct packed {
    op_e     op;
    handle_t key;
    handle_t value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // lowest set bit index, zero when none
  function automatic idx_t first_one(logic [Entries-1:0] v);
    idx_t r;
    r = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] slot_field(idx_t idx);
    logic [IdxW+3:0] w;
    w = (IdxW + 4)'(idx);
    return w[3:0];
  endfunction

endpackage

// ===== sv/akvt_front.sv =====
// ----------------------------------------------------------------------------
// akvt_front
// Request intake: accepts a command and classifies it for the back end.
// ----------------------------------------------------------------------------
module akvt_front (
  input  logic              start_i,
  input  akvt_pkg::req_t    req_i,
  input  akvt_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output akvt_pkg::item_t   item_o
);
  import akvt_pkg::*;

  assign push_o = start_i && !q_stat_i.full;

  always_comb begin
    item_o.key   = req_i.key_handle;
    item_o.value = req_i.value_handle;
    unique case (req_i.kind)
      KIND_SET: begin
        item_o.op = (req_i.key_handle == '0 || req_i.value_handle == '0) ? OP_BAD : OP_SET;
      end
      KIND_GET: begin
        item_o.op = (req_i.key_handle == '0) ? OP_BAD : OP_GET;
      end
      KIND_CLR_KEY: begin
        item_o.op = (req_i.key_handle == '0) ? OP_BAD : OP_CLR_KEY;
      end
      KIND_CLR_VAL: begin
        item_o.op = (req_i.value_handle == '0) ? OP_BAD : OP_CLR_VAL;
      end
      default: begin
        item_o.op = OP_BAD;
      end
    endcase
  end

endmodule

// ===== sv/akvt_queue.sv =====
// ----------------------------------------------------------------------------
// akvt_queue
// Small FIFO decoupling request intake from table execution.
// ----------------------------------------------------------------------------
module akvt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  akvt_pkg::item_t   item_i,
  input  logic              pop_i,
  output akvt_pkg::item_t   item_o,
  output akvt_pkg::q_stat_t stat_o
);
  import akvt_pkg::*;

  item_t              slot_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/akvt_back.sv =====
// ----------------------------------------------------------------------------
// akvt_back
// Table execution: parallel match over all slots, update, registered result.
// ----------------------------------------------------------------------------
module akvt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  akvt_pkg::q_stat_t q_stat_i,
  input  akvt_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              done_o,
  output akvt_pkg::rsp_t    rsp_o
);
  import akvt_pkg::*;

  handle_t              key_q [Entries];
  handle_t              val_q [Entries];
  logic [Entries-1:0]   key_hit, val_hit, empty;
  idx_t                 key_idx, val_idx, free_idx, sel_idx;
  logic                 wr_en;
  handle_t              wr_key, wr_val;
  rsp_t                 rsp_d, rsp_q;
  logic                 done_q;

  // never stalls: results cannot be held off downstream
  assign pop_o = !q_stat_i.empty;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      key_hit[i] = (key_q[i] == item_i.key);
      val_hit[i] = (val_q[i] == item_i.value);
      empty[i]   = (key_q[i] == '0);
    end
  end

  assign key_idx  = first_one(key_hit);
  assign val_idx  = first_one(val_hit);
  assign free_idx = first_one(empty);

  always_comb begin
    unique case (item_i.op)
      OP_SET:     sel_idx = (|key_hit) ? key_idx : free_idx;
      OP_CLR_VAL: sel_idx = val_idx;
      default:    sel_idx = key_idx;
    endcase
  end

  always_comb begin
    rsp_d.status          = ST_BAD;
    rsp_d.result_value    = '0;
    rsp_d.displaced_value = '0;
    rsp_d.slot_index      = '0;
    wr_en                 = 1'b0;
    wr_key                = '0;
    wr_val                = '0;
    unique case (item_i.op) inside
      OP_SET: begin
        if (|key_hit || |empty) begin
          wr_en                 = 1'b1;
          wr_key                = item_i.key;
          wr_val                = item_i.value;
          rsp_d.status          = ST_DONE;
          rsp_d.result_value    = item_i.value;
          rsp_d.displaced_value = val_q[sel_idx];
          rsp_d.slot_index      = slot_field(sel_idx);
        end else begin
          // refused value goes back for software to free
          rsp_d.status          = ST_FULL;
          rsp_d.displaced_value = item_i.value;
        end
      end
      OP_GET: begin
        if (|key_hit) begin
          rsp_d.status       = ST_FOUND;
          rsp_d.result_value = val_q[sel_idx];
          rsp_d.slot_index   = slot_field(sel_idx);
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      OP_CLR_KEY, OP_CLR_VAL: begin
        if ((item_i.op == OP_CLR_KEY) ? |key_hit : |val_hit) begin
          wr_en                 = 1'b1;
          rsp_d.status          = ST_DONE;
          rsp_d.displaced_value = val_q[sel_idx];
          rsp_d.slot_index      = slot_field(sel_idx);
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      default: begin
        rsp_d.status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        key_q[i] <= '0;
        val_q[i] <= '0;
      end
    end else if (pop_o && wr_en) begin
      key_q[sel_idx] <= wr_key;
      val_q[sel_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/assoc_key_value_table.sv =====
// ----------------------------------------------------------------------------
// assoc_key_value_table
// Fully associative 16-slot table of key/value handle pairs with set, get,
// clear-by-key and clear-by-value commands.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  command   | start / busy       | req_i  (kind, key_handle, value_handle)
//  result    | done_o (strobe)    | rsp_o  (status, result_value,
//            |                    |         displaced_value, slot_index)
//
//  One command per cycle while busy is low; the result strobe follows the
//  transfer through the queue entry and then the registered result of the
//  back end's 16-way compare, priority pick and table update.
//  Async active-low reset empties every slot at once; no clearing pass.
//  The result side cannot stall, so the back end drains the queue every cycle
//  and busy stays low in practice; it reflects a full queue.
// ----------------------------------------------------------------------------
`include "assoc_key_value_table_macros.svh"

module assoc_key_value_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  akvt_pkg::req_t req_i,
  output logic           done_o,
  output akvt_pkg::rsp_t rsp_o
);
  import akvt_pkg::*;

  logic    push, pop;
  item_t   fr_item, bk_item;
  q_stat_t q_stat;

  // intake: zero handles are flagged here so the back end sees clean ops
  akvt_front u_front (
    .start_i  (start),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (fr_item)
  );

  akvt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fr_item),
    .pop_i  (pop),
    .item_o (bk_item),
    .stat_o (q_stat)
  );

  // execution against the table; results come out registered
  akvt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .item_i   (bk_item),
    .pop_o    (pop),
    .done_o   (done_o),
    .rsp_o    (rsp_o)
  );

  assign busy = q_stat.full;

  // every transfer produces a result once it has passed the queue and the back end's result register
  `AKVT_ASSERT_NEXT(a_xfer_done, clk_i, rst_ni, start && !busy, ##1 done_o)
  // a pop always yields a strobe on the next cycle
  `AKVT_ASSERT_NEXT(a_pop_done, clk_i, rst_ni, pop, done_o)
  // back end drains at full rate, so the queue never fills
  `AKVT_ASSERT_IMPLY(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  // a full table refuses without touching a slot
  `AKVT_ASSERT_IMPLY(a_full_clean, clk_i, rst_ni, done_o && rsp_o.status == ST_FULL, rsp_o.slot_index == '0 && rsp_o.result_value == '0)

endmodule
